// ===== rtl/keypad_code_lock_motor_sequencer_core_macros.svh =====
// Assertion macros shared by the keypad lock RTL.
`ifndef KEYPAD_CODE_LOCK_MOTOR_SEQUENCER_CORE_MACROS_SVH
`define KEYPAD_CODE_LOCK_MOTOR_SEQUENCER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked on every clock edge, off while reset is low.
`define KCLM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define KCLM_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define KCLM_ASSERT(lbl, clk, rst_n, prop, msg)
`define KCLM_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/kclm_pkg.sv =====
// Types and constants for the keypad code lock and motor sequencer.
package kclm_pkg;

    localparam int KEY_WIDTH    = 9;
    localparam int KEY_COUNT    = 9;
    localparam int CODE_LENGTH  = 4;
    localparam int CODE_SLOTS   = 4;
    localparam int THRESH_WIDTH = 16;
    localparam int CFG_WIDTH    = 16;
    localparam int CFG_IDX_W    = 3;

    // keys at KEY_COUNT and above are ignored
    localparam logic [KEY_WIDTH-1:0] KEY_VALID =
        KEY_WIDTH'((33'd1 << KEY_COUNT) - 33'd1);

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [1:0] DRIVE_OFF = 2'd0;
    localparam logic [1:0] DRIVE_FWD = 2'd1;
    localparam logic [1:0] DRIVE_REV = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CODE_FIRST    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_SECOND   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_THIRD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_FOURTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_END   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_START = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQUENCE_END  = 3'd7;

    localparam logic [KEY_WIDTH-1:0]    RST_CODE_FIRST    = 9'd1;
    localparam logic [KEY_WIDTH-1:0]    RST_CODE_SECOND   = 9'd2;
    localparam logic [KEY_WIDTH-1:0]    RST_CODE_THIRD    = 9'd4;
    localparam logic [KEY_WIDTH-1:0]    RST_CODE_FOURTH   = 9'd8;
    localparam logic [THRESH_WIDTH-1:0] RST_LOCKOUT       = 16'd50;
    localparam logic [THRESH_WIDTH-1:0] RST_FORWARD_END   = 16'd4200;
    localparam logic [THRESH_WIDTH-1:0] RST_REVERSE_START = 16'd4700;
    localparam logic [THRESH_WIDTH-1:0] RST_SEQUENCE_END  = 16'd6700;

    typedef struct packed {
        logic                 opcode;
        logic [KEY_WIDTH-1:0] key_mask;
    } t_in_item;

    typedef struct packed {
        logic [1:0] motor_drive;
        logic       press_indicator;
        logic [1:0] code_position;
        logic       unlocked_pulse;
    } t_out_item;

    typedef logic [CODE_SLOTS-1:0][KEY_WIDTH-1:0] t_code_set;

    // post-update status of the keypad side for the item just processed
    typedef struct packed {
        logic       indicator;
        logic [1:0] position;
        logic       unlocked;
    } t_lock_result;

    typedef enum logic [1:0] {
        PH_FORWARD = 2'd0,
        PH_GAP     = 2'd1,
        PH_REVERSE = 2'd2
    } t_phase;

endpackage

// ===== rtl/kclm_lock.sv =====
// Keypad press detection, lockout timer and code matching.
module kclm_lock #(
    parameter int TICK_WIDTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_step,
    input  kclm_pkg::t_in_item                      i_item,
    input  kclm_pkg::t_code_set                     i_code,
    input  logic [kclm_pkg::THRESH_WIDTH-1:0]       i_lockout_ticks,
    output kclm_pkg::t_lock_result                  o_result
);

    localparam int CW = (TICK_WIDTH > kclm_pkg::THRESH_WIDTH) ?
                        TICK_WIDTH : kclm_pkg::THRESH_WIDTH;

    logic [1:0]            r_pos,     n_pos;
    logic                  r_held,    n_held;
    logic                  r_enabled, n_enabled;
    logic                  r_run,     n_run;
    logic [TICK_WIDTH-1:0] r_elapsed, n_elapsed;
    logic                  r_ind,     n_ind;
    logic                  n_unlocked;

    always_comb begin
        logic [kclm_pkg::KEY_WIDTH-1:0] keys;
        logic [2:0]                     pos_inc;
        keys       = i_item.key_mask & kclm_pkg::KEY_VALID;
        pos_inc    = {1'b0, r_pos} + 3'd1;
        n_pos      = r_pos;
        n_held     = r_held;
        n_enabled  = r_enabled;
        n_run      = r_run;
        n_elapsed  = r_elapsed;
        n_ind      = r_ind;
        n_unlocked = 1'b0;
        if (i_item.opcode == kclm_pkg::OP_TICK) begin
            if (r_run && !(&r_elapsed)) begin
                n_elapsed = r_elapsed + TICK_WIDTH'(1);
            end
        end else if (keys != '0) begin
            n_run     = 1'b1;
            n_elapsed = '0;
            if (!r_held && r_enabled) begin
                n_held    = 1'b1;
                n_enabled = 1'b0;
                n_ind     = 1'b1;
                if ($onehot(keys)) begin
                    if (i_code[r_pos] != keys) begin
                        n_pos = 2'd0;
                    end else if (pos_inc >= 3'(kclm_pkg::CODE_LENGTH)) begin
                        n_pos      = 2'd0;
                        n_unlocked = 1'b1;
                    end else begin
                        n_pos = pos_inc[1:0];
                    end
                end else begin
                    n_pos = 2'd0;
                end
            end
        end else begin
            n_held = 1'b0;
        end
        // lockout end is tested on the updated count
        if (n_run && (CW'(n_elapsed) >= CW'(i_lockout_ticks))) begin
            n_ind     = 1'b0;
            n_run     = 1'b0;
            n_elapsed = '0;
            n_enabled = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 2'd0;
            r_held    <= 1'b0;
            r_enabled <= 1'b1;
            r_run     <= 1'b0;
            r_elapsed <= '0;
            r_ind     <= 1'b0;
        end else if (i_step) begin
            r_pos     <= n_pos;
            r_held    <= n_held;
            r_enabled <= n_enabled;
            r_run     <= n_run;
            r_elapsed <= n_elapsed;
            r_ind     <= n_ind;
        end
    end

    assign o_result.indicator = n_ind;
    assign o_result.position  = n_pos;
    assign o_result.unlocked  = n_unlocked;

endmodule

// ===== rtl/kclm_motor.sv =====
// Timed motor sequence: forward, off, reverse, off.
module kclm_motor #(
    parameter int TICK_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic                              i_tick,
    input  logic                              i_start,
    input  logic [kclm_pkg::THRESH_WIDTH-1:0] i_forward_end,
    input  logic [kclm_pkg::THRESH_WIDTH-1:0] i_reverse_start,
    input  logic [kclm_pkg::THRESH_WIDTH-1:0] i_sequence_end,
    output logic [1:0]                        o_drive
);

    localparam int CW = (TICK_WIDTH > kclm_pkg::THRESH_WIDTH) ?
                        TICK_WIDTH : kclm_pkg::THRESH_WIDTH;

    kclm_pkg::t_phase      r_phase,   n_phase;
    logic                  r_run,     n_run;
    logic [TICK_WIDTH-1:0] r_elapsed, n_elapsed;

    // next state; phases are tested in order so one item can pass several
    always_comb begin
        n_phase   = r_phase;
        n_run     = r_run;
        n_elapsed = r_elapsed;
        if (i_tick && r_run && !(&r_elapsed)) begin
            n_elapsed = r_elapsed + TICK_WIDTH'(1);
        end
        if (i_start) begin
            n_run     = 1'b1;
            n_elapsed = '0;
            n_phase   = kclm_pkg::PH_FORWARD;
        end
        if (n_run) begin
            if (n_phase == kclm_pkg::PH_FORWARD &&
                CW'(n_elapsed) >= CW'(i_forward_end)) begin
                n_phase = kclm_pkg::PH_GAP;
            end
            if (n_phase == kclm_pkg::PH_GAP &&
                CW'(n_elapsed) >= CW'(i_reverse_start)) begin
                n_phase = kclm_pkg::PH_REVERSE;
            end
            if (n_phase == kclm_pkg::PH_REVERSE &&
                CW'(n_elapsed) >= CW'(i_sequence_end)) begin
                n_phase   = kclm_pkg::PH_FORWARD;
                n_run     = 1'b0;
                n_elapsed = '0;
            end
        end
    end

    // drive follows the updated phase
    always_comb begin
        o_drive = kclm_pkg::DRIVE_OFF;
        if (n_run) begin
            unique case (n_phase)
                kclm_pkg::PH_FORWARD: o_drive = kclm_pkg::DRIVE_FWD;
                kclm_pkg::PH_GAP:     o_drive = kclm_pkg::DRIVE_OFF;
                kclm_pkg::PH_REVERSE: o_drive = kclm_pkg::DRIVE_REV;
                default:              o_drive = kclm_pkg::DRIVE_OFF;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= kclm_pkg::PH_FORWARD;
            r_run     <= 1'b0;
            r_elapsed <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_run     <= n_run;
            r_elapsed <= n_elapsed;
        end
    end

endmodule

// ===== rtl/keypad_code_lock_motor_sequencer_core.sv =====
// Keypad code lock with motor sequencer: top level with config and pipeline.
// Items pass through an input register, then the lock and motor update logic
// into the result register, which drives the output valid and data.
// Throughput: one item per cycle; only a stalled result register holds back input.
// Reset (synchronous, active low) clears lock and motor state and loads the
// default code keys and tick thresholds.
`include "keypad_code_lock_motor_sequencer_core_macros.svh"
module keypad_code_lock_motor_sequencer_core #(
    parameter int TICK_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  kclm_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output kclm_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [kclm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kclm_pkg::CFG_WIDTH-1:0]      i_cfg_data
);

    kclm_pkg::t_code_set                r_code;
    logic [kclm_pkg::THRESH_WIDTH-1:0]  r_lockout;
    logic [kclm_pkg::THRESH_WIDTH-1:0]  r_forward_end;
    logic [kclm_pkg::THRESH_WIDTH-1:0]  r_reverse_start;
    logic [kclm_pkg::THRESH_WIDTH-1:0]  r_sequence_end;

    logic                   r_in_valid;
    kclm_pkg::t_in_item     r_in_item;
    logic                   r_out_valid;
    kclm_pkg::t_out_item    r_out_item;
    kclm_pkg::t_out_item    n_out_item;

    logic                   advance;
    logic                   step;
    logic                   in_xfer;
    kclm_pkg::t_lock_result lock_res;
    logic [1:0]             drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code[0]       <= kclm_pkg::RST_CODE_FIRST;
            r_code[1]       <= kclm_pkg::RST_CODE_SECOND;
            r_code[2]       <= kclm_pkg::RST_CODE_THIRD;
            r_code[3]       <= kclm_pkg::RST_CODE_FOURTH;
            r_lockout       <= kclm_pkg::RST_LOCKOUT;
            r_forward_end   <= kclm_pkg::RST_FORWARD_END;
            r_reverse_start <= kclm_pkg::RST_REVERSE_START;
            r_sequence_end  <= kclm_pkg::RST_SEQUENCE_END;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kclm_pkg::CFG_CODE_FIRST:
                    r_code[0] <= i_cfg_data[kclm_pkg::KEY_WIDTH-1:0];
                kclm_pkg::CFG_CODE_SECOND:
                    r_code[1] <= i_cfg_data[kclm_pkg::KEY_WIDTH-1:0];
                kclm_pkg::CFG_CODE_THIRD:
                    r_code[2] <= i_cfg_data[kclm_pkg::KEY_WIDTH-1:0];
                kclm_pkg::CFG_CODE_FOURTH:
                    r_code[3] <= i_cfg_data[kclm_pkg::KEY_WIDTH-1:0];
                kclm_pkg::CFG_LOCKOUT:       r_lockout       <= i_cfg_data;
                kclm_pkg::CFG_FORWARD_END:   r_forward_end   <= i_cfg_data;
                kclm_pkg::CFG_REVERSE_START: r_reverse_start <= i_cfg_data;
                kclm_pkg::CFG_SEQUENCE_END:  r_sequence_end  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // result register frees up when empty or when its transfer completes
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign step       = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= i_in_data;
        end
    end

    kclm_lock #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_lock (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_item          (r_in_item),
        .i_code          (r_code),
        .i_lockout_ticks (r_lockout),
        .o_result        (lock_res)
    );

    kclm_motor #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_motor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_tick          (r_in_item.opcode == kclm_pkg::OP_TICK),
        .i_start         (lock_res.unlocked),
        .i_forward_end   (r_forward_end),
        .i_reverse_start (r_reverse_start),
        .i_sequence_end  (r_sequence_end),
        .o_drive         (drive)
    );

    always_comb begin
        n_out_item.motor_drive     = drive;
        n_out_item.press_indicator = lock_res.indicator;
        n_out_item.code_position   = lock_res.position;
        n_out_item.unlocked_pulse  = lock_res.unlocked;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    `KCLM_ASSERT(a_stall_needs_item, i_clk, i_rst_n, o_in_stall |-> r_in_valid, "input stalled with empty input register")
    `KCLM_ASSERT_NEXT(a_step_gives_result, i_clk, i_rst_n, step, r_out_valid, "processed item produced no result")
    `KCLM_ASSERT(a_unlock_resets_pos, i_clk, i_rst_n, (o_out_valid && o_out_data.unlocked_pulse) |-> (o_out_data.code_position == 2'd0), "code completed but position not cleared")
    `KCLM_ASSERT(a_drive_legal, i_clk, i_rst_n, o_out_valid |-> (o_out_data.motor_drive != 2'd3), "illegal motor drive code")

endmodule
